/* rtl/csdm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csdm_pkg;

  // sector codes, one per quarter of the square
  typedef enum logic [1:0] {
    SECT_RIGHT = 2'd0,
    SECT_TOP   = 2'd1,
    SECT_LEFT  = 2'd2,
    SECT_BOT   = 2'd3
  } csdm_sect_e;

  // input coordinate width and square-center code
  localparam int unsigned CoordW = 16;
  localparam int unsigned OutW   = 18;
  localparam logic [CoordW-1:0] CoordHalf = 16'h8000;

  // reciprocal of pi/4
  localparam real InvPi4 = 4.0 / 3.14159265358979323846;

  // sideband that rides along the divider cells
  typedef struct packed {
    logic [16:0] radius;
    csdm_sect_e  sect;
    logic        minus;
    logic        origin;
  } csdm_side_t;

  // octant angle atan(2^-i) / (pi/4), truncated to frac fraction bits
  function automatic longint ang_fix(int i, int frac);
    real a;
    // first stage is exactly one octant
    if (i == 0) begin
      return 64'sd1 <<< frac;
    end
    a = $atan(2.0 ** (-i)) * InvPi4 * (2.0 ** frac);
    return longint'($floor(a));
  endfunction

  // rotation gain over n stages in Q.30
  function automatic longint gain_q30(int n);
    real g;
    g = 1.0;
    for (int i = 0; i < n; i++) begin
      g = g * $cos($atan(2.0 ** (-i)));
    end
    return longint'($floor(g * (2.0 ** 30)));
  endfunction

endpackage

`default_nettype wire

/* rtl/csdm_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module csdm_div_cell
  import csdm_pkg::*;
#(
  parameter int unsigned QW    = 17,
  parameter bit          FIRST = 1'b0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [17:0]   rem_i,
  input  wire logic [16:0]   den_i,
  input  wire logic [QW-1:0] quo_i,
  input  wire csdm_side_t    side_i,
  output logic               valid_o,
  output logic [17:0]        rem_o,
  output logic [16:0]        den_o,
  output logic [QW-1:0]      quo_o,
  output csdm_side_t         side_o
);

  logic [17:0]   rem_sh;
  logic          ge;
  logic [17:0]   rem_d;
  logic [QW-1:0] quo_d;

  // one restoring step: shift, compare, subtract
  always_comb begin
    rem_sh = FIRST ? rem_i : {rem_i[16:0], 1'b0};
    ge     = rem_sh >= {1'b0, den_i};
    rem_d  = ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
    quo_d  = FIRST ? QW'(ge) : {quo_i[QW-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    den_o  <= den_i;
    quo_o  <= quo_d;
    side_o <= side_i;
  end

endmodule

`default_nettype wire

/* rtl/csdm_rot_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module csdm_rot_cell
  import csdm_pkg::*;
#(
  parameter int unsigned W         = 19,
  parameter int unsigned STAGE     = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic signed [W-1:0] x_i,
  input  wire logic signed [W-1:0] y_i,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic [1:0]    quad_i,
  output logic               valid_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] a_o,
  output logic [1:0]         quad_o
);

  localparam logic signed [W-1:0] Ang = W'(ang_fix(STAGE, FRAC_BITS));

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic signed [W-1:0] x_d;
  logic signed [W-1:0] y_d;
  logic signed [W-1:0] a_d;

  // one micro-rotation toward zero residual angle
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (a_i >= 0) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      a_d = a_i - Ang;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      a_d = a_i + Ang;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    a_o    <= a_d;
    quad_o <= quad_i;
  end

endmodule

`default_nettype wire

/* rtl/concentric_square_to_disk_map_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Concentric square-to-disk mapping.
// Input: start_i with u_coord_i / v_coord_i (unsigned Q0.16). An item is
// taken at every clock edge where start_i is high and busy_o is low; busy_o
// stays low, so one item can enter in every cycle.
// Output: done_o strobes for one cycle with disk_x_o / disk_y_o (signed
// Q1.16). Results leave in the order the items came in.
// Pipeline: one sector stage, FRAC_BITS + 1 divider cells (one quotient
// bit each), one angle/gain stage, ROTATION_STAGES rotation cells and one
// output stage.
// Throughput: one item per cycle; every cell is a plain pipeline register
// stage, so nothing is shared between items.
// The receiver cannot hold results off; each strobe appears exactly once.
// Reset clears all valid bits; items in flight are dropped, the
// data registers are left as they are.

module concentric_square_to_disk_map_top
  import csdm_pkg::*;
#(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [15:0]       u_coord_i,
  input  wire logic [15:0]       v_coord_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [17:0]     disk_x_o,
  output logic signed [17:0]     disk_y_o
);

  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned W     = FRAC_BITS + 3;
  localparam int unsigned TW    = FRAC_BITS + 5;
  localparam int unsigned OW    = W + 9;
  localparam int unsigned Lat   = FRAC_BITS + ROTATION_STAGES + 4;
  localparam int unsigned ShDn  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned ShUp  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam longint      Rnd   = (FRAC_BITS > 16) ? (64'sd1 <<< (FRAC_BITS - 17)) : 0;
  localparam logic [30:0] Gain  = 31'(gain_q30(ROTATION_STAGES));
  localparam logic signed [TW-1:0] One = TW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [OW-1:0] SatHi = OW'(65536);
  localparam logic signed [OW-1:0] SatLo = -OW'(65536);

  assign busy_o = 1'b0;

  // sector selection
  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic signed [17:0] num;
  logic signed [17:0] den;
  csdm_side_t         side_d;

  always_comb begin
    xs = $signed({1'b0, u_coord_i, 1'b0}) - 18'sd65536;
    ys = $signed({1'b0, v_coord_i, 1'b0}) - 18'sd65536;
    side_d.origin = 1'b0;
    if (xs > -ys) begin
      if (xs > ys) begin
        side_d.sect   = SECT_RIGHT;
        side_d.radius = 17'(xs);
        side_d.minus  = ys < 0;
        num = ys;
        den = xs;
      end else begin
        side_d.sect   = SECT_TOP;
        side_d.radius = 17'(ys);
        side_d.minus  = !(xs < 0);
        num = xs;
        den = ys;
      end
    end else begin
      if (xs < ys) begin
        side_d.sect   = SECT_LEFT;
        side_d.radius = 17'(-xs);
        side_d.minus  = !(ys < 0);
        num = ys;
        den = xs;
      end else begin
        side_d.sect   = SECT_BOT;
        side_d.radius = 17'(-ys);
        side_d.minus  = xs < 0;
        side_d.origin = ys == 0;
        num = xs;
        den = ys;
      end
    end
  end

  logic               s0_valid_q;
  logic [17:0]        s0_rem_q;
  logic [16:0]        s0_den_q;
  csdm_side_t         s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_rem_q  <= {1'b0, 17'((num < 0) ? -num : num)};
    s0_den_q  <= 17'((den < 0) ? -den : den);
    s0_side_q <= side_d;
  end

  // divider chain, one quotient bit per cell
  logic              dv_valid [0:QW];
  logic [17:0]       dv_rem   [0:QW];
  logic [16:0]       dv_den   [0:QW];
  logic [QW-1:0]     dv_quo   [0:QW];
  csdm_side_t        dv_side  [0:QW];

  assign dv_valid[0] = s0_valid_q;
  assign dv_rem[0]   = s0_rem_q;
  assign dv_den[0]   = s0_den_q;
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = s0_side_q;

  for (genvar g = 0; g < QW; g++) begin : g_div
    csdm_div_cell #(
      .QW    (QW),
      .FIRST (g == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[g]),
      .rem_i   (dv_rem[g]),
      .den_i   (dv_den[g]),
      .quo_i   (dv_quo[g]),
      .side_i  (dv_side[g]),
      .valid_o (dv_valid[g+1]),
      .rem_o   (dv_rem[g+1]),
      .den_o   (dv_den[g+1]),
      .quo_o   (dv_quo[g+1]),
      .side_o  (dv_side[g+1])
    );
  end

  // angle in octants, quarter turns, residual, scaled start vector
  csdm_side_t          sd;
  logic signed [TW-1:0] t;
  logic signed [TW-1:0] tp;
  logic signed [TW-1:0] mag;
  logic [47:0]          prod;
  logic [47:0]          prod_sh;
  logic signed [W-1:0]  a0;
  logic signed [W-1:0]  cx0;
  logic [1:0]           q0;

  always_comb begin
    sd   = dv_side[QW];
    mag  = $signed({{(TW-QW){1'b0}}, dv_quo[QW]});
    t    = $signed(TW'({sd.sect, 1'b0})) <<< FRAC_BITS;
    t    = sd.minus ? (t - mag) : (t + mag);
    if (sd.origin) begin
      t = '0;
    end
    tp   = t + One;
    q0   = tp[FRAC_BITS+2:FRAC_BITS+1];
    a0   = $signed({2'b00, tp[FRAC_BITS:0]}) - W'(One);
    prod = 48'(sd.radius) * 48'(Gain);
    prod_sh = prod >> (46 - FRAC_BITS);
    cx0  = $signed(prod_sh[W-1:0]);
  end

  logic              rv_valid [0:ROTATION_STAGES];
  logic signed [W-1:0] rv_x   [0:ROTATION_STAGES];
  logic signed [W-1:0] rv_y   [0:ROTATION_STAGES];
  logic signed [W-1:0] rv_a   [0:ROTATION_STAGES];
  logic [1:0]        rv_quad  [0:ROTATION_STAGES];

  logic                s1_valid_q;
  logic signed [W-1:0] s1_x_q;
  logic signed [W-1:0] s1_a_q;
  logic [1:0]          s1_quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q    <= cx0;
    s1_a_q    <= a0;
    s1_quad_q <= q0;
  end

  assign rv_valid[0] = s1_valid_q;
  assign rv_x[0]     = s1_x_q;
  assign rv_y[0]     = '0;
  assign rv_a[0]     = s1_a_q;
  assign rv_quad[0]  = s1_quad_q;

  // rotation chain
  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_rot
    csdm_rot_cell #(
      .W         (W),
      .STAGE     (g),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv_valid[g]),
      .x_i     (rv_x[g]),
      .y_i     (rv_y[g]),
      .a_i     (rv_a[g]),
      .quad_i  (rv_quad[g]),
      .valid_o (rv_valid[g+1]),
      .x_o     (rv_x[g+1]),
      .y_o     (rv_y[g+1]),
      .a_o     (rv_a[g+1]),
      .quad_o  (rv_quad[g+1])
    );
  end

  // scale to Q.16 with round half up, then clamp to the unit range
  function automatic logic signed [17:0] to_out(input logic signed [W-1:0] v);
    logic signed [OW-1:0] o;
    o = OW'(v);
    o = (o + OW'(Rnd)) >>> ShDn;
    o = o <<< ShUp;
    if (o > SatHi) begin
      o = SatHi;
    end
    if (o < SatLo) begin
      o = SatLo;
    end
    return o[17:0];
  endfunction

  // quarter turns applied exactly
  logic signed [W-1:0] fx;
  logic signed [W-1:0] fy;
  logic signed [W-1:0] ox;
  logic signed [W-1:0] oy;
  logic                unused_a;

  always_comb begin
    fx = rv_x[ROTATION_STAGES];
    fy = rv_y[ROTATION_STAGES];
    unused_a = ^rv_a[ROTATION_STAGES];
    case (rv_quad[ROTATION_STAGES])
      2'd1: begin
        ox = -fy;
        oy = fx;
      end
      2'd2: begin
        ox = -fx;
        oy = -fy;
      end
      2'd3: begin
        ox = fy;
        oy = -fx;
      end
      default: begin
        ox = fx;
        oy = fy;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= rv_valid[ROTATION_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    disk_x_o <= to_out(ox) ^ {17'd0, unused_a & 1'b0};
    disk_y_o <= to_out(oy);
  end

  // every accepted item leaves after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o)
    else $error("item did not leave after fixed latency");

  // the square center maps to the disk center
  a_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && u_coord_i == CoordHalf && v_coord_i == CoordHalf
    |-> ##Lat (disk_x_o == 0 && disk_y_o == 0))
    else $error("center did not map to origin");

  // results stay inside the clamp range
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (disk_x_o <= 18'sd65536 && disk_x_o >= -18'sd65536 &&
                disk_y_o <= 18'sd65536 && disk_y_o >= -18'sd65536))
    else $error("result outside unit range");

endmodule

`default_nettype wire

/* tb/sv/disk_map_checker.sv */
`timescale 1ns / 1ps

module disk_map_checker
  import csdm_pkg::*;
#(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [CoordW-1:0]        u_coord_i,
  input  logic [CoordW-1:0]        v_coord_i,
  input  logic                     done_i,
  input  logic signed [OutW-1:0]   disk_x_i,
  input  logic signed [OutW-1:0]   disk_y_i,
  output int                       fail_cnt_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
  } disk_pt_t;

  disk_pt_t  disk_pt_q[$];
  longint    octant_ang[ROTATION_STAGES];
  longint    rot_gain;
  int        fail_cnt;

  // atan(1/n) in Q60 by its power series
  function automatic longint unsigned atan_inv_q60(longint unsigned n);
    longint unsigned p, sum, term, k;
    p = (64'd1 << 60) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  // atan(2^-i) in Q60
  function automatic longint unsigned atan_pow2_q60(int unsigned i);
    longint unsigned p, sum, term, k;
    p = (i >= 60) ? 0 : (64'd1 << (60 - i));
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = (2 * i >= 60) ? 0 : (p >> (2 * i));
      k++;
    end
    return sum;
  endfunction

  // restoring division a/b with FRAC_BITS fraction bits
  function automatic longint unsigned frac_quot(longint unsigned a, longint unsigned b);
    longint unsigned q, rem;
    q = 0;
    rem = a;
    if (b == 0) return 0;
    if (rem >= b) begin
      q = 1;
      rem = rem - b;
    end
    for (int k = 0; k < FRAC_BITS; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // signed ratio in Q.FRAC_BITS, truncated toward zero
  function automatic longint sgn_ratio(longint num, longint den);
    longint an, ad, mag;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (ad == 0) return 0;
    mag = (an << FRAC_BITS) / ad;
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  // bring to Q1.16 and clamp to the unit range
  function automatic logic [OutW-1:0] to_q16(longint v);
    longint o;
    if (FRAC_BITS > 16) o = (v + (64'sd1 <<< (FRAC_BITS - 17))) >>> (FRAC_BITS - 16);
    else o = v <<< (16 - FRAC_BITS);
    if (o > 65536) o = 65536;
    if (o < -65536) o = -65536;
    return o[OutW-1:0];
  endfunction

  function automatic disk_pt_t map_to_disk(logic [CoordW-1:0] u, logic [CoordW-1:0] v);
    longint one, x, y, r, t, q, a, cx, cy, dx, dy, ox, oy;
    disk_pt_t pt;
    one = 64'sd1 <<< FRAC_BITS;
    x = 2 * longint'(u) - 65536;
    y = 2 * longint'(v) - 65536;
    // sector pick: radius and angle in octants
    if (x > -y) begin
      if (x > y) begin
        r = x;
        t = sgn_ratio(y, x);
      end else begin
        r = y;
        t = 2 * one - sgn_ratio(x, y);
      end
    end else begin
      if (x < y) begin
        r = -x;
        t = 4 * one + sgn_ratio(y, x);
      end else begin
        r = -y;
        t = (y != 0) ? 6 * one - sgn_ratio(x, y) : 0;
      end
    end
    q = (t + one) / (2 * one);
    a = t - q * 2 * one;
    // rotate the residual angle
    cx = (r * rot_gain) >>> (46 - FRAC_BITS);
    cy = 0;
    for (int i = 0; i < ROTATION_STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (a >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        a = a - octant_ang[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        a = a + octant_ang[i];
      end
    end
    // whole quarter turns
    case (q & 3)
      1: begin ox = -cy; oy = cx; end
      2: begin ox = -cx; oy = -cy; end
      3: begin ox = cy; oy = -cx; end
      default: begin ox = cx; oy = cy; end
    endcase
    pt.x = to_q16(ox);
    pt.y = to_q16(oy);
    return pt;
  endfunction

  // angle table and gain from integer series
  initial begin
    longint unsigned pi4, k2, ang;
    pi4 = 4 * atan_inv_q60(5) - atan_inv_q60(239);
    k2 = 64'd1 << 60;
    for (int unsigned i = 0; i < ROTATION_STAGES; i++) begin
      ang = (i == 0) ? pi4 : atan_pow2_q60(i);
      octant_ang[i] = longint'(frac_quot(ang, pi4));
      if (2 * i < 62) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
    end
    rot_gain = longint'(int_sqrt(k2));
  end

  // predict on accepted items, compare on strobed results
  always @(posedge clk_i or negedge rst_ni) begin
    disk_pt_t exp_pt;
    if (!rst_ni) begin
      disk_pt_q.delete();
      fail_cnt = 0;
    end else begin
      if (done_i) begin
        if (disk_pt_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", disk_x_i, disk_y_i);
          fail_cnt++;
        end else begin
          exp_pt = disk_pt_q.pop_front();
          if (disk_x_i !== exp_pt.x) begin
            $error("disk_x expected %0d actual %0d", $signed(exp_pt.x), disk_x_i);
            fail_cnt++;
          end
          if (disk_y_i !== exp_pt.y) begin
            $error("disk_y expected %0d actual %0d", $signed(exp_pt.y), disk_y_i);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_i) begin
        disk_pt_q.insert(disk_pt_q.size(), map_to_disk(u_coord_i, v_coord_i));
      end
    end
  end

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = disk_pt_q.size();

endmodule

/* tb/sv/tb_concentric_square_to_disk_map_top.sv */
`timescale 1ns / 1ps

module tb_concentric_square_to_disk_map_top;
  import csdm_pkg::*;

  localparam int CycleLimit = 200000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic [CoordW-1:0]      u_coord_i;
  logic [CoordW-1:0]      v_coord_i;
  logic                   busy_o;
  logic                   done_o;
  logic signed [OutW-1:0] disk_x_o;
  logic signed [OutW-1:0] disk_y_o;
  int                     fail_cnt;
  int                     pending;
  int                     cycle_cnt;
  int                     item_cnt;

  concentric_square_to_disk_map_top u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .u_coord_i (u_coord_i),
    .v_coord_i (v_coord_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .disk_x_o  (disk_x_o),
    .disk_y_o  (disk_y_o)
  );

  disk_map_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .u_coord_i  (u_coord_i),
    .v_coord_i  (v_coord_i),
    .done_i     (done_o),
    .disk_x_i   (disk_x_o),
    .disk_y_i   (disk_y_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_point(logic [CoordW-1:0] u, logic [CoordW-1:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    u_coord_i <= u;
    v_coord_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    item_cnt++;
  endtask

  // random point, biased toward sector borders and the center
  task automatic send_random(int idle_pct);
    logic [CoordW-1:0] u, v;
    u = CoordW'($urandom);
    case ($urandom_range(9))
      0: v = u;
      1: v = CoordW'(17'h10000 - u);
      2: begin
        u = CoordW'(CoordHalf + $urandom_range(8) - 4);
        v = CoordW'(CoordHalf + $urandom_range(8) - 4);
      end
      default: v = CoordW'($urandom);
    endcase
    send_point(u, v, idle_pct);
  endtask

  initial begin
    int idle_pct[3] = '{29, 84, 0};
    cycle_cnt = 0;
    item_cnt  = 0;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    u_coord_i = '0;
    v_coord_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, center, sector borders and edge midpoints
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'h0000, 16'hFFFF, 0);
    send_point(16'hFFFF, 16'h0000, 0);
    send_point(CoordHalf, CoordHalf, 0);
    send_point(CoordHalf, 16'h0000, 0);
    send_point(CoordHalf, 16'hFFFF, 0);
    send_point(16'h0000, CoordHalf, 0);
    send_point(16'hFFFF, CoordHalf, 0);
    send_point(16'h8001, CoordHalf, 0);
    send_point(16'h7FFF, CoordHalf, 0);
    send_point(CoordHalf, 16'h8001, 0);
    send_point(CoordHalf, 16'h7FFF, 0);
    send_point(16'hC000, 16'hC000, 0);
    send_point(16'h4000, 16'hC000, 0);
    send_point(16'h4000, 16'h4000, 0);
    send_point(16'hC000, 16'h4000, 0);
    send_point(16'h8001, 16'h8001, 0);
    send_point(16'h7FFF, 16'h8001, 0);
    send_point(16'hAAAA, 16'h5555, 0);
    send_point(16'h5555, 16'hAAAA, 0);

    // drain fully once before the random part
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 650; n++) send_random(idle_pct[ph]);
    end
    start_i <= 1'b0;

    while (pending != 0 && cycle_cnt < CycleLimit) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
    end

    $display("covered %0d points: corners, center, sector borders, random fill", item_cnt);
    $display("source idle at 29 and 84 percent, then back to back, with a full drain");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
